/* rtl/quadratic_bezier_midpoint_subdivide_macros.svh */
// ----------------------------------------------------------------------------
// Quadratic Bezier subdivider assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_BEZIER_MIDPOINT_SUBDIVIDE_MACROS_SVH
`define QUADRATIC_BEZIER_MIDPOINT_SUBDIVIDE_MACROS_SVH

// Same-cycle implication: the consequent holds whenever the antecedent does.
`define QBMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qbms assertion failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define QBMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qbms assertion failed");

`endif

/* rtl/qbms_pkg.sv */
// ----------------------------------------------------------------------------
// Quadratic Bezier subdivider package
// Default parameters, field widths and the microcode table of the sequencer.
// ----------------------------------------------------------------------------
package qbms_pkg;

    // Default parameter values and fixed field widths.
    localparam int MAX_LEVELS_DEF  = 5;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int CFG_W           = 3;
    localparam logic [CFG_W-1:0] LEVELS_RESET = 3'd3;

    // Microcode step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_FETCH    = 3'd0;
    localparam logic [STEP_W-1:0] ST_EMIT_A   = 3'd1;
    localparam logic [STEP_W-1:0] ST_TEST     = 3'd2;
    localparam logic [STEP_W-1:0] ST_HALF     = 3'd3;
    localparam logic [STEP_W-1:0] ST_PUSH     = 3'd4;
    localparam logic [STEP_W-1:0] ST_POP_CHK  = 3'd5;
    localparam logic [STEP_W-1:0] ST_POP_LOAD = 3'd6;
    localparam logic [STEP_W-1:0] ST_EMIT_END = 3'd7;

    // Jump conditions.
    localparam logic [1:0] JC_NEXT   = 2'd0;
    localparam logic [1:0] JC_ALWAYS = 2'd1;
    localparam logic [1:0] JC_LEAF   = 2'd2;
    localparam logic [1:0] JC_EMPTY  = 2'd3;

    // One control word per step.
    typedef struct packed {
        logic              load_in;
        logic              emit;
        logic              emit_end;
        logic              half;
        logic              push;
        logic              pop_rd;
        logic              pop_ld;
        logic [1:0]        jcond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // The program: fetch, emit the start point, descend to the leaves by
    // pushing right halves, then pop and emit each pending start point, then the end point.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        case (step)
            ST_FETCH:
            begin
                w.load_in = 1'b1;
            end
            ST_EMIT_A:
            begin
                w.emit = 1'b1;
            end
            ST_TEST:
            begin
                w.jcond  = JC_LEAF;
                w.target = ST_POP_CHK;
            end
            ST_HALF:
            begin
                w.half = 1'b1;
            end
            ST_PUSH:
            begin
                w.push   = 1'b1;
                w.jcond  = JC_ALWAYS;
                w.target = ST_TEST;
            end
            ST_POP_CHK:
            begin
                w.pop_rd = 1'b1;
                w.jcond  = JC_EMPTY;
                w.target = ST_EMIT_END;
            end
            ST_POP_LOAD:
            begin
                w.pop_ld = 1'b1;
                w.jcond  = JC_ALWAYS;
                w.target = ST_EMIT_A;
            end
            ST_EMIT_END:
            begin
                w.emit     = 1'b1;
                w.emit_end = 1'b1;
                w.jcond    = JC_ALWAYS;
                w.target   = ST_FETCH;
            end
            default:
            begin
                w.jcond  = JC_ALWAYS;
                w.target = ST_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/qbms_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/quadratic_bezier_midpoint_subdivide.sv */
// ----------------------------------------------------------------------------
// Quadratic Bezier midpoint subdivider
// Takes three control points on the input channel (in_valid/in_stall) and
// emits the curve points on the output channel (out_valid/out_stall): the
// start point, the 2^L-1 interior midpoints left to right, then the end
// point with last_point set. L is the level register written on the cfg
// channel (cfg_ready is always high), saturated to MAX_LEVELS.
// A microcoded sequencer steps through a small program; right halves wait
// on a stack RAM of one triangle per row. Each split runs the test, half
// and push steps, each pop the pop-check and pop-load steps through the
// registered stack read, and each point one emit step. The first point
// enters the output register at the emit step that follows the fetch.
// A new item is taken only after the end point has been placed in the
// output register. A stalled output holds the sequencer at its emit step.
// Reset empties the sequencer and output register and sets L to 3.
// ----------------------------------------------------------------------------
`include "quadratic_bezier_midpoint_subdivide_macros.svh"

module quadratic_bezier_midpoint_subdivide #(
    parameter int MAX_LEVELS  = qbms_pkg::MAX_LEVELS_DEF,
    parameter int COORD_WIDTH = qbms_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qbms_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [qbms_pkg::FIELD_W-1:0] p0_x,
    input  logic signed [qbms_pkg::FIELD_W-1:0] p0_y,
    input  logic signed [qbms_pkg::FIELD_W-1:0] p1_x,
    input  logic signed [qbms_pkg::FIELD_W-1:0] p1_y,
    input  logic signed [qbms_pkg::FIELD_W-1:0] p2_x,
    input  logic signed [qbms_pkg::FIELD_W-1:0] p2_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [qbms_pkg::FIELD_W-1:0] curve_x,
    output logic signed [qbms_pkg::FIELD_W-1:0] curve_y,
    output logic                                last_point
);

    localparam int W      = COORD_WIDTH;
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
    localparam int SP_W   = $clog2(MAX_LEVELS + 1);
    localparam int ADDR_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int ROW_W  = 6 * W + LVL_W;

    // Floor midpoint of two coordinates, computed one bit wider.
    function automatic logic signed [W-1:0] midpoint(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return s[W:1];
    endfunction

    // Sequencer and configuration state.
    logic [qbms_pkg::STEP_W-1:0] step_reg, step_next;
    logic [qbms_pkg::CFG_W-1:0]  levels_cfg_reg;
    logic [LVL_W-1:0]            levels_run_reg;
    logic [LVL_W-1:0]            level_reg;
    logic [SP_W-1:0]             sp_reg;
    qbms_pkg::ucode_t            ucode;

    // Datapath registers.
    logic signed [W-1:0] a_x_reg, a_y_reg, b_x_reg, b_y_reg, c_x_reg, c_y_reg;
    logic signed [W-1:0] end_x_reg, end_y_reg;
    logic signed [W-1:0] m1_x_reg, m1_y_reg, m2_x_reg, m2_y_reg;
    logic signed [W-1:0] m3_x, m3_y;

    // Output register.
    logic                out_valid_reg;
    logic                out_last_reg;
    logic signed [W-1:0] out_x_reg, out_y_reg;

    logic             in_accept;
    logic             out_free;
    logic             wait_step;
    logic             jump_taken;
    logic [SP_W-1:0]  sp_dec;
    logic [LVL_W-1:0] levels_sat;
    logic [ROW_W-1:0] push_row;
    logic [ROW_W-1:0] pop_row;

    assign ucode     = qbms_pkg::ucode_rom(step_reg);
    assign cfg_ready = 1'b1;
    assign in_stall  = !ucode.load_in;
    assign in_accept = in_valid && ucode.load_in;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sp_dec    = sp_reg - 1'b1;
    assign m3_x      = midpoint(m1_x_reg, m2_x_reg);
    assign m3_y      = midpoint(m1_y_reg, m2_y_reg);

    // Levels above the supported depth saturate.
    assign levels_sat = (levels_cfg_reg > qbms_pkg::CFG_W'(MAX_LEVELS))
                      ? LVL_W'(MAX_LEVELS) : LVL_W'(levels_cfg_reg);

    // Right half of the current triangle, with the level it will resume at.
    assign push_row = {m3_x, m3_y, m2_x_reg, m2_y_reg, c_x_reg, c_y_reg,
                       LVL_W'(level_reg + 1'b1)};

    // Pending right halves, one triangle per row.
    qbms_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_LEVELS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ucode.push),
        .wr_addr (sp_reg[ADDR_W-1:0]),
        .wr_data (push_row),
        .rd_addr (sp_dec[ADDR_W-1:0]),
        .rd_data (pop_row)
    );

    // Jump condition and step sequencing.
    always_comb
    begin
        case (ucode.jcond)
            qbms_pkg::JC_NEXT:   jump_taken = 1'b0;
            qbms_pkg::JC_ALWAYS: jump_taken = 1'b1;
            qbms_pkg::JC_LEAF:   jump_taken = (level_reg >= levels_run_reg);
            qbms_pkg::JC_EMPTY:  jump_taken = (sp_reg == '0);
            default:             jump_taken = 1'b0;
        endcase
        wait_step = (ucode.load_in && !in_valid) || (ucode.emit && !out_free);
        if (wait_step)
        begin
            step_next = step_reg;
        end
        else if (jump_taken)
        begin
            step_next = ucode.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= qbms_pkg::ST_FETCH;
            levels_cfg_reg <= qbms_pkg::LEVELS_RESET;
            levels_run_reg <= '0;
            level_reg      <= '0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_valid)
            begin
                levels_cfg_reg <= cfg_data;
            end
            if (in_accept)
            begin
                levels_run_reg <= levels_sat;
                level_reg      <= '0;
                sp_reg         <= '0;
            end
            if (ucode.push)
            begin
                level_reg <= LVL_W'(level_reg + 1'b1);
                sp_reg    <= SP_W'(sp_reg + 1'b1);
            end
            if (ucode.pop_rd && !jump_taken)
            begin
                sp_reg <= sp_dec;
            end
            if (ucode.pop_ld)
            begin
                level_reg <= pop_row[LVL_W-1:0];
            end
            if (ucode.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_x_reg   <= p0_x[W-1:0];
            a_y_reg   <= p0_y[W-1:0];
            b_x_reg   <= p1_x[W-1:0];
            b_y_reg   <= p1_y[W-1:0];
            c_x_reg   <= p2_x[W-1:0];
            c_y_reg   <= p2_y[W-1:0];
            end_x_reg <= p2_x[W-1:0];
            end_y_reg <= p2_y[W-1:0];
        end
        if (ucode.half)
        begin
            m1_x_reg <= midpoint(a_x_reg, b_x_reg);
            m1_y_reg <= midpoint(a_y_reg, b_y_reg);
            m2_x_reg <= midpoint(b_x_reg, c_x_reg);
            m2_y_reg <= midpoint(b_y_reg, c_y_reg);
        end
        if (ucode.push)
        begin
            b_x_reg <= m1_x_reg;
            b_y_reg <= m1_y_reg;
            c_x_reg <= m3_x;
            c_y_reg <= m3_y;
        end
        if (ucode.pop_ld)
        begin
            {a_x_reg, a_y_reg, b_x_reg, b_y_reg, c_x_reg, c_y_reg} <= pop_row[ROW_W-1:LVL_W];
        end
        if (ucode.emit && out_free)
        begin
            out_x_reg    <= ucode.emit_end ? end_x_reg : a_x_reg;
            out_y_reg    <= ucode.emit_end ? end_y_reg : a_y_reg;
            out_last_reg <= ucode.emit_end;
        end
    end

    // Output ports, sign-extended to the field width.
    assign out_valid  = out_valid_reg;
    assign curve_x    = qbms_pkg::FIELD_W'(out_x_reg);
    assign curve_y    = qbms_pkg::FIELD_W'(out_y_reg);
    assign last_point = out_last_reg;

    // Checks on the sequencer and the stack.
    `QBMS_ASSERT_IMPL(a_sp_bound, clk, rst_n, 1'b1, sp_reg <= SP_W'(MAX_LEVELS))
    `QBMS_ASSERT_IMPL(a_level_bound, clk, rst_n, 1'b1, level_reg <= levels_run_reg)
    `QBMS_ASSERT_NEXT(a_start_clean, clk, rst_n, in_accept,
        (sp_reg == '0) && (level_reg == '0) && (step_reg == qbms_pkg::ST_EMIT_A))
    `QBMS_ASSERT_NEXT(a_end_last, clk, rst_n, ucode.emit && ucode.emit_end && out_free,
        out_valid_reg && out_last_reg && (step_reg == qbms_pkg::ST_FETCH))

endmodule

/* tb/sv/tb_quadratic_bezier_midpoint_subdivide.sv */
// ----------------------------------------------------------------------------
// Quadratic Bezier midpoint subdivider testbench
// Sends control-point triangles through the input channel and compares every
// emitted curve point against a de Casteljau predictor kept in the bench. The
// level register is swept over its whole range, saturating values included,
// while the sender idles and the receiver stalls in several patterns, and one
// phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_quadratic_bezier_midpoint_subdivide;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W           = qbms_pkg::FIELD_W;
    localparam int LVL_MAX     = qbms_pkg::MAX_LEVELS_DEF;
    localparam int STACK_PTS   = 3 * LVL_MAX;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE      = 16;

    typedef logic signed [W-1:0] coord_t;

    // One triangle of control points.
    typedef struct {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p2_x;
        coord_t p2_y;
    } triangle_t;

    // One emitted curve point.
    typedef struct {
        coord_t x;
        coord_t y;
        logic   last_pt;
    } curve_point_t;

    typedef enum {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } flow_mode_t;

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [qbms_pkg::CFG_W-1:0] cfg_data = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    coord_t                 p0_x       = '0;
    coord_t                 p0_y       = '0;
    coord_t                 p1_x       = '0;
    coord_t                 p1_y       = '0;
    coord_t                 p2_x       = '0;
    coord_t                 p2_y       = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    coord_t                 curve_x;
    coord_t                 curve_y;
    logic                   last_point;

    triangle_t              curves_to_send[$];
    curve_point_t           predicted_points[$];
    logic [qbms_pkg::CFG_W-1:0] levels_copy = qbms_pkg::LEVELS_RESET;
    flow_mode_t             flow_mode   = FLOW_FREE;
    logic                   in_taken    = 1'b0;
    logic                   hold_req    = 1'b0;
    logic                   hold_ack    = 1'b0;
    int                     hold_left   = 0;
    int                     idle_cycles = 0;
    int                     error_count = 0;

    quadratic_bezier_midpoint_subdivide i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .p0_x       (p0_x),
        .p0_y       (p0_y),
        .p1_x       (p1_x),
        .p1_y       (p1_y),
        .p2_x       (p2_x),
        .p2_y       (p2_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .curve_x    (curve_x),
        .curve_y    (curve_y),
        .last_point (last_point)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Floor of the half sum, taken on a widened sum so it cannot overflow.
    function automatic coord_t halve_sum(input coord_t a, input coord_t b);
        logic signed [W:0] s;
        s = a + b;
        return s[W:1];
    endfunction

    function automatic void expect_point(input coord_t x, input coord_t y, input logic lp);
        curve_point_t pt;
        pt.x       = x;
        pt.y       = y;
        pt.last_pt = lp;
        predicted_points.push_back(pt);
    endfunction

    // De Casteljau subdivision with an explicit stack of right halves.
    function automatic void predict_curve_points(input triangle_t t,
                                                 input logic [qbms_pkg::CFG_W-1:0] lv_cfg);
        coord_t      ax, ay, bx, by, cx, cy;
        coord_t      m1x, m1y, m2x, m2y, m3x, m3y;
        coord_t      sx[STACK_PTS];
        coord_t      sy[STACK_PTS];
        int unsigned slvl[LVL_MAX];
        int unsigned depth, cur, sp;
        ax = t.p0_x; ay = t.p0_y;
        bx = t.p1_x; by = t.p1_y;
        cx = t.p2_x; cy = t.p2_y;
        depth = (lv_cfg > LVL_MAX) ? LVL_MAX : lv_cfg;
        expect_point(ax, ay, 1'b0);
        sp  = 0;
        cur = 0;
        while (1)
        begin
            // Descend along the left halves, parking each right half.
            while (cur < depth && sp + 3 <= STACK_PTS)
            begin
                m1x = halve_sum(ax, bx);   m1y = halve_sum(ay, by);
                m2x = halve_sum(bx, cx);   m2y = halve_sum(by, cy);
                m3x = halve_sum(m1x, m2x); m3y = halve_sum(m1y, m2y);
                sx[sp]     = m3x; sy[sp]     = m3y;
                sx[sp + 1] = m2x; sy[sp + 1] = m2y;
                sx[sp + 2] = cx;  sy[sp + 2] = cy;
                slvl[sp / 3] = cur + 1;
                sp  = sp + 3;
                bx  = m1x; by = m1y;
                cx  = m3x; cy = m3y;
                cur = cur + 1;
            end
            if (sp < 3)
                break;
            // Resume with the most recent right half and emit its start.
            sp  = sp - 3;
            ax  = sx[sp];     ay = sy[sp];
            bx  = sx[sp + 1]; by = sy[sp + 1];
            cx  = sx[sp + 2]; cy = sy[sp + 2];
            cur = slvl[sp / 3];
            expect_point(ax, ay, 1'b0);
        end
        expect_point(t.p2_x, t.p2_y, 1'b1);
    endfunction

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_idle();
        case (flow_mode)
            FLOW_SEND_IDLE: return chance(88);
            FLOW_BOTH:      return chance(23);
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_busy();
        case (flow_mode)
            FLOW_RECV_STALL: return chance(88);
            FLOW_BOTH:       return chance(23);
            default:         return 1'b0;
        endcase
    endfunction

    // Coordinates mix full-range values, the extremes and small values near zero.
    function automatic coord_t random_coord();
        case ($urandom_range(7))
            0:       return {1'b0, {(W-1){1'b1}}};
            1:       return {1'b1, {(W-1){1'b0}}};
            2:       return $urandom_range(15) - 8;
            3:       return $urandom_range(32'h0003_ffff) - 32'h0002_0000;
            4:       return {1'b1, {(W-1){1'b0}}} + $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_triangle(input coord_t ax, input coord_t ay, input coord_t bx,
                                 input coord_t by, input coord_t cx, input coord_t cy);
        triangle_t t;
        t.p0_x = ax; t.p0_y = ay;
        t.p1_x = bx; t.p1_y = by;
        t.p2_x = cx; t.p2_y = cy;
        curves_to_send.push_back(t);
    endtask

    // Waits until every triangle has been sent and every point has come back.
    task automatic settle();
        do
            @(negedge clk);
        while (curves_to_send.size() != 0 || in_valid || predicted_points.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Writes the level register once the block has gone idle.
    task automatic start_phase(input logic [qbms_pkg::CFG_W-1:0] lv, input flow_mode_t mode);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= lv;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        flow_mode = mode;
    endtask

    task automatic random_phase(input logic [qbms_pkg::CFG_W-1:0] lv, input flow_mode_t mode,
                                input int count, input bit hold_off);
        start_phase(lv, mode);
        for (int i = 0; i < count; i++)
            push_triangle(random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord());
        if (hold_off)
            hold_req = ~hold_req;
    endtask

    // Input driver: a new triangle goes out only after the last one transferred.
    always @(negedge clk)
    begin : drive_triangles
        triangle_t t;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (curves_to_send.size() != 0 && !sender_idle())
            begin
                t = curves_to_send.pop_front();
                p0_x     <= t.p0_x;
                p0_y     <= t.p0_y;
                p1_x     <= t.p1_x;
                p1_y     <= t.p1_y;
                p2_x     <= t.p2_x;
                p2_y     <= t.p2_y;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random per the flow mode, or a long counted hold-off.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= receiver_busy();
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge clk)
    begin : check_points
        curve_point_t exp_pt;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                levels_copy <= cfg_data;
            if (in_valid && !in_stall)
            begin
                exp_pt.x = '0;
                predict_curve_points('{p0_x, p0_y, p1_x, p1_y, p2_x, p2_y}, levels_copy);
            end
            if (out_valid && !out_stall)
            begin
                if (predicted_points.size() == 0)
                begin
                    $display("%0t: unexpected point x %h y %h last %b",
                             $time, curve_x, curve_y, last_point);
                    error_count++;
                end
                else
                begin
                    exp_pt = predicted_points.pop_front();
                    if (curve_x !== exp_pt.x)
                    begin
                        $display("%0t: curve_x expected %h actual %h", $time, exp_pt.x, curve_x);
                        error_count++;
                    end
                    if (curve_y !== exp_pt.y)
                    begin
                        $display("%0t: curve_y expected %h actual %h", $time, exp_pt.y, curve_y);
                        error_count++;
                    end
                    if (last_point !== exp_pt.last_pt)
                    begin
                        $display("%0t: last_point expected %b actual %b",
                                 $time, exp_pt.last_pt, last_point);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_quadratic_bezier_midpoint_subdivide: errors");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset level: zeros, both extremes, opposing extremes, floor cases.
        push_triangle(0, 0, 0, 0, 0, 0);
        push_triangle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        push_triangle(32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_triangle(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        push_triangle(-1, 1, 0, -1, 1, 0);
        push_triangle(3, -3, -5, 7, 1, -1);

        // Zero levels: only the two endpoints come out.
        start_phase(0, FLOW_FREE);
        push_triangle(-1, 32'sh7fffffff, 5, 6, 32'sh80000000, 1);
        push_triangle(32'sh7fffffff, 32'sh80000000, 0, 0, -7, 9);
        push_triangle(0, 0, 0, 0, 0, 0);

        // Deepest level.
        start_phase(LVL_MAX, FLOW_FREE);
        push_triangle(32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        push_triangle(-1, -1, 1, 1, -3, 3);
        push_triangle(32'sh00010000, 32'shffff0000, 32'sh12345678,
                      32'shedcba987, 32'sh7fff0001, 32'sh8000ffff);

        // Level values above the limit saturate.
        start_phase(7, FLOW_FREE);
        push_triangle(32'sh7fffffff, 0, 32'sh80000000, -1, 32'sh7fffffff, 1);
        push_triangle(-9, 11, 13, -15, 17, -19);
        start_phase(6, FLOW_FREE);
        push_triangle(1, -1, -1, 1, 1, -1);
        push_triangle(32'sh80000001, 32'sh7ffffffe, 0, 0, 32'sh7ffffffe, 32'sh80000001);

        start_phase(1, FLOW_FREE);
        push_triangle(-2, 3, -4, 5, -6, 7);
        push_triangle(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                      32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);

        // Random phases over levels and flow patterns.
        random_phase(1, FLOW_FREE,       40, 1'b0);
        random_phase(2, FLOW_SEND_IDLE,  40, 1'b0);
        random_phase(3, FLOW_RECV_STALL, 40, 1'b0);
        random_phase(4, FLOW_BOTH,       40, 1'b0);
        random_phase(0, FLOW_FREE,       40, 1'b0);
        random_phase(5, FLOW_SEND_IDLE,  20, 1'b0);
        random_phase(6, FLOW_RECV_STALL, 15, 1'b0);
        random_phase(2, FLOW_BOTH,       40, 1'b0);
        random_phase(1, FLOW_FREE,       30, 1'b1);
        random_phase(7, FLOW_FREE,       10, 1'b0);
        random_phase(3, FLOW_SEND_IDLE,  30, 1'b0);
        random_phase(4, FLOW_RECV_STALL, 25, 1'b0);

        settle();
        if (error_count == 0)
            $display("tb_quadratic_bezier_midpoint_subdivide: clean");
        else
            $display("tb_quadratic_bezier_midpoint_subdivide: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qbms_pkg.sv
rtl/qbms_ram.sv
rtl/quadratic_bezier_midpoint_subdivide.sv
tb/sv/tb_quadratic_bezier_midpoint_subdivide.sv
